// ----- design/pte_pkg.sv -----
// Shared constants, codes and types of the prefix trie engine.
package pte_pkg;

   localparam int NODE_COUNT    = 1024;
   localparam int ALPHABET_SIZE = 26;
   localparam int LINK_DEPTH    = NODE_COUNT * ALPHABET_SIZE;

   localparam int NODE_W   = $clog2(NODE_COUNT);
   localparam int FREE_W   = NODE_W + 1;
   localparam int LINK_AW  = $clog2(LINK_DEPTH);
   localparam int KIND_W   = 2;
   localparam int LETTER_W = 5;

   // request kinds; the unused code behaves as prefix search
   localparam logic [KIND_W-1:0] REQ_INSERT = 2'd0;
   localparam logic [KIND_W-1:0] REQ_SEARCH = 2'd1;
   localparam logic [KIND_W-1:0] REQ_PREFIX = 2'd2;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP,
      ST_FINISH,
      ST_REPLY
   } state_type;

   typedef struct packed {
      logic              en;
      logic [LINK_AW-1:0] addr;
      logic [NODE_W-1:0]  data;
   } link_wr_type;

   typedef struct packed {
      logic              en;
      logic [NODE_W-1:0] addr;
      logic              data;
   } term_wr_type;

   typedef struct packed {
      logic valid;
      logic hit;
      logic no_room;
   } result_type;

endpackage

// ----- design/pte_ram.sv -----
// Generic single write, single read synchronous RAM with registered read data.
module pte_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, registered read data
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/pte_walker.sv -----
// Walk sequencer: clearing pass, per-letter link lookup and allocation, word results.
module pte_walker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [pte_pkg::KIND_W-1:0]    req_type,
   input  logic [pte_pkg::LETTER_W-1:0]  req_letter,
   input  logic                          req_last_letter,
   input  logic                          req_empty_word,
   input  logic                          out_free,
   output pte_pkg::result_type           result,
   output logic [pte_pkg::LINK_AW-1:0]   link_raddr,
   input  logic [pte_pkg::NODE_W-1:0]    link_rdata,
   output pte_pkg::link_wr_type          link_wr,
   output logic [pte_pkg::NODE_W-1:0]    term_raddr,
   input  logic                          term_rdata,
   output pte_pkg::term_wr_type          term_wr
);
   import pte_pkg::*;

   state_type          state_ff, state_in;
   logic [LINK_AW-1:0] clear_ff, clear_in;
   logic [KIND_W-1:0]  kind_ff, kind_in;
   logic               last_ff, last_in;
   logic [LINK_AW-1:0] slot_ff, slot_in;
   logic [NODE_W-1:0]  walk_node_ff, walk_node_in;
   logic               walk_failed_ff, walk_failed_in;
   logic               pool_exh_ff, pool_exh_in;
   logic [FREE_W-1:0]  next_free_ff, next_free_in;

   logic accept;
   logic letter_bad;
   logic clear_done;
   logic pool_full;
   logic [LINK_AW-1:0] slot;

   assign accept     = req_valid && (state_ff == ST_IDLE);
   assign letter_bad = 32'(req_letter) >= ALPHABET_SIZE;
   assign clear_done = clear_ff == LINK_AW'(LINK_DEPTH - 1);
   assign pool_full  = next_free_ff >= FREE_W'(NODE_COUNT);
   assign slot       = LINK_AW'(walk_node_ff) * LINK_AW'(ALPHABET_SIZE) + LINK_AW'(req_letter);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clear_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) begin
               if (req_empty_word) begin
                  state_in = ST_FINISH;
               end else if (walk_failed_ff || letter_bad) begin
                  state_in = req_last_letter ? ST_FINISH : ST_IDLE;
               end else begin
                  state_in = ST_LOOKUP;
               end
            end
         end
         ST_LOOKUP: state_in = last_ff ? ST_FINISH : ST_IDLE;
         ST_FINISH: state_in = ST_REPLY;
         ST_REPLY: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // outputs: stall, memory accesses and result
   always_comb begin
      req_stall      = state_ff != ST_IDLE;
      link_raddr     = slot;
      term_raddr     = walk_node_ff;
      link_wr        = '0;
      term_wr        = '0;
      result         = '0;
      case (state_ff)
         ST_CLEAR: begin
            link_wr.en   = 1'b1;
            link_wr.addr = clear_ff;
            term_wr.en   = 32'(clear_ff) < NODE_COUNT;
            term_wr.addr = clear_ff[NODE_W-1:0];
         end
         ST_LOOKUP: begin
            // allocate a missing child for an insert while the node pool has room
            link_wr.en   = (link_rdata == '0) && (kind_ff == REQ_INSERT) && !pool_full;
            link_wr.addr = slot_ff;
            link_wr.data = next_free_ff[NODE_W-1:0];
         end
         ST_REPLY: begin
            result.valid = out_free;
            case (kind_ff)
               REQ_INSERT: begin
                  result.hit     = !walk_failed_ff;
                  result.no_room = walk_failed_ff && pool_exh_ff;
                  term_wr.en     = out_free && !walk_failed_ff;
                  term_wr.addr   = walk_node_ff;
                  term_wr.data   = 1'b1;
               end
               REQ_SEARCH: result.hit = !walk_failed_ff && term_rdata;
               default:    result.hit = !walk_failed_ff;
            endcase
         end
         default: ;
      endcase
   end

   // walk state updates
   always_comb begin
      clear_in       = clear_ff;
      kind_in        = kind_ff;
      last_in        = last_ff;
      slot_in        = slot_ff;
      walk_node_in   = walk_node_ff;
      walk_failed_in = walk_failed_ff;
      pool_exh_in    = pool_exh_ff;
      next_free_in   = next_free_ff;
      case (state_ff)
         ST_CLEAR: clear_in = clear_ff + LINK_AW'(1);
         ST_IDLE: begin
            if (accept) begin
               kind_in = req_type;
               last_in = req_last_letter;
               slot_in = slot;
               if (!req_empty_word && letter_bad) walk_failed_in = 1'b1;
            end
         end
         ST_LOOKUP: begin
            if (link_rdata != '0) begin
               walk_node_in = link_rdata;
            end else if (kind_ff != REQ_INSERT) begin
               walk_failed_in = 1'b1;
            end else if (pool_full) begin
               walk_failed_in = 1'b1;
               pool_exh_in    = 1'b1;
            end else begin
               walk_node_in = next_free_ff[NODE_W-1:0];
               next_free_in = next_free_ff + FREE_W'(1);
            end
         end
         ST_REPLY: begin
            // word done: back to the root
            if (out_free) begin
               walk_node_in   = '0;
               walk_failed_in = 1'b0;
               pool_exh_in    = 1'b0;
            end
         end
         default: ;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         clear_ff       <= '0;
         walk_node_ff   <= '0;
         walk_failed_ff <= 1'b0;
         pool_exh_ff    <= 1'b0;
         next_free_ff   <= FREE_W'(1);
      end else begin
         state_ff       <= state_in;
         clear_ff       <= clear_in;
         walk_node_ff   <= walk_node_in;
         walk_failed_ff <= walk_failed_in;
         pool_exh_ff    <= pool_exh_in;
         next_free_ff   <= next_free_in;
      end
   end

   // request capture
   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      last_ff <= last_in;
      slot_ff <= slot_in;
   end

endmodule

// ----- design/prefix_trie_engine_unit.sv -----
// Per letter the walker accepts the item in ST_IDLE, then reads the registered child link in
// ST_LOOKUP (skipped for a bad letter or a failed walk); a word end adds ST_FINISH (terminal-mark
// read) and ST_REPLY (result register load); rsp_valid comes from that output register.
// The link RAM read per letter sets the rate; a full output register holds the walker.
// After reset a clearing pass over all NODE_COUNT*ALPHABET_SIZE (26624) link addresses zeroes the
// link and terminal RAMs; req_stall stays high during it.
module prefix_trie_engine_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [pte_pkg::KIND_W-1:0]    req_type,
   input  logic [pte_pkg::LETTER_W-1:0]  req_letter,
   input  logic                          req_last_letter,
   input  logic                          req_empty_word,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_hit,
   output logic                          rsp_no_room
);
   import pte_pkg::*;

   result_type         result;
   link_wr_type        link_wr;
   term_wr_type        term_wr;
   logic [LINK_AW-1:0] link_raddr;
   logic [NODE_W-1:0]  link_rdata;
   logic [NODE_W-1:0]  term_raddr;
   logic               term_rdata;
   logic               out_free;

   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_hit_ff, rsp_hit_in;
   logic rsp_no_room_ff, rsp_no_room_in;

   pte_walker u_walker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_type        (req_type),
      .req_letter      (req_letter),
      .req_last_letter (req_last_letter),
      .req_empty_word  (req_empty_word),
      .out_free        (out_free),
      .result          (result),
      .link_raddr      (link_raddr),
      .link_rdata      (link_rdata),
      .link_wr         (link_wr),
      .term_raddr      (term_raddr),
      .term_rdata      (term_rdata),
      .term_wr         (term_wr)
   );

   // child links, one entry per node and letter
   pte_ram #(.WIDTH(NODE_W), .DEPTH(LINK_DEPTH)) u_link_ram (
      .clock   (clock),
      .wr_en   (link_wr.en),
      .wr_addr (link_wr.addr),
      .wr_data (link_wr.data),
      .rd_addr (link_raddr),
      .rd_data (link_rdata)
   );

   // terminal marks, one per node
   pte_ram #(.WIDTH(1), .DEPTH(NODE_COUNT)) u_term_ram (
      .clock   (clock),
      .wr_en   (term_wr.en),
      .wr_addr (term_wr.addr),
      .wr_data (term_wr.data),
      .rd_addr (term_raddr),
      .rd_data (term_rdata)
   );

   // output register
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_hit_in     = rsp_hit_ff;
      rsp_no_room_in = rsp_no_room_ff;
      if (result.valid) begin
         rsp_valid_in   = 1'b1;
         rsp_hit_in     = result.hit;
         rsp_no_room_in = result.no_room;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_hit_ff     <= rsp_hit_in;
      rsp_no_room_ff <= rsp_no_room_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_hit     = rsp_hit_ff;
   assign rsp_no_room = rsp_no_room_ff;

endmodule

// ----- sim/prefix_trie_engine_unit_tb.sv -----
// Self-checking testbench for the prefix trie engine: directed words, random words, pool fill.
`timescale 1ns / 100ps

module prefix_trie_engine_unit_tb;
   import pte_pkg::*;

   localparam int HALF_PERIOD  = 10;
   localparam int RESET_CYCLES = 10;
   localparam int QUIET_LIMIT  = 100000;   // outlasts the clearing pass
   localparam int DRAIN_CYCLES = 10;
   localparam int MAX_LEN      = 16;
   localparam int DICT_SIZE    = 32;

   localparam logic [KIND_W-1:0]   REQ_SPARE  = 2'd3;
   localparam logic [LETTER_W-1:0] LETTER_A   = '0;
   localparam logic [LETTER_W-1:0] LETTER_B   = 5'd1;
   localparam logic [LETTER_W-1:0] LETTER_D   = 5'd3;
   localparam logic [LETTER_W-1:0] LETTER_Z   = LETTER_W'(ALPHABET_SIZE - 1);
   localparam logic [LETTER_W-1:0] LETTER_BAD = LETTER_W'(ALPHABET_SIZE);
   localparam logic [LETTER_W-1:0] LETTER_MAX = '1;

   typedef struct packed {
      logic hit;
      logic no_room;
   } verdict_type;

   logic                clock           = 1'b0;
   logic                reset           = 1'b1;
   logic                req_valid       = 1'b0;
   logic                req_stall;
   logic [KIND_W-1:0]   req_type        = REQ_INSERT;
   logic [LETTER_W-1:0] req_letter      = LETTER_A;
   logic                req_last_letter = 1'b0;
   logic                req_empty_word  = 1'b0;
   logic                rsp_valid;
   logic                rsp_stall       = 1'b0;
   logic                rsp_hit;
   logic                rsp_no_room;

   // shadow trie
   logic [NODE_W-1:0]   link_mem [LINK_DEPTH];
   logic                term_mem [NODE_COUNT];
   logic [FREE_W-1:0]   free_ptr;
   logic [NODE_W-1:0]   cur_node;
   logic                path_broken;
   logic                out_of_nodes;
   verdict_type         pending_verdicts [$];

   // word under construction and a small store of inserted words
   logic [LETTER_W-1:0] word_letter [MAX_LEN];
   logic [KIND_W-1:0]   word_kind   [MAX_LEN];
   int                  word_len;
   logic [LETTER_W-1:0] dict_letter [DICT_SIZE][MAX_LEN];
   int                  dict_len    [DICT_SIZE];
   int                  dict_count  = 0;
   int                  dict_next   = 0;

   logic idle_on       = 1'b1;
   int   stall_left    = 0;
   int   quiet_cycles  = 0;
   int   requests_sent = 0;
   int   results_seen  = 0;
   int   hits_seen     = 0;
   int   refusals_seen = 0;
   int   fail_count    = 0;

   prefix_trie_engine_unit u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_type        (req_type),
      .req_letter      (req_letter),
      .req_last_letter (req_last_letter),
      .req_empty_word  (req_empty_word),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_hit         (rsp_hit),
      .rsp_no_room     (rsp_no_room)
   );

   always #HALF_PERIOD clock = ~clock;

   // shadow trie update for one accepted request; queues the verdict at word end
   function automatic void predict_request(input logic [KIND_W-1:0] kind,
                                           input logic [LETTER_W-1:0] letter,
                                           input logic last, input logic empty);
      int          slot;
      verdict_type v;
      if (!empty && !path_broken) begin
         if (int'(letter) >= ALPHABET_SIZE) begin
            path_broken = 1'b1;
         end else begin
            slot = int'(cur_node) * ALPHABET_SIZE + int'(letter);
            if (link_mem[slot] == '0 && kind != REQ_INSERT) begin
               path_broken = 1'b1;
            end else if (link_mem[slot] == '0 && int'(free_ptr) >= NODE_COUNT) begin
               path_broken  = 1'b1;
               out_of_nodes = 1'b1;
            end else begin
               if (link_mem[slot] == '0) begin
                  link_mem[slot] = free_ptr[NODE_W-1:0];
                  free_ptr       = free_ptr + 1'b1;
               end
               cur_node = link_mem[slot];
            end
         end
      end
      if (!empty && !last)
         return;
      // word ends: the ending request's kind decides
      v = '0;
      case (kind)
         REQ_INSERT: begin
            if (!path_broken) begin
               term_mem[cur_node] = 1'b1;
               v.hit              = 1'b1;
            end else begin
               v.no_room = out_of_nodes;
            end
         end
         REQ_SEARCH: v.hit = !path_broken && term_mem[cur_node];
         default:    v.hit = !path_broken;
      endcase
      pending_verdicts.push_back(v);
      cur_node     = '0;
      path_broken  = 1'b0;
      out_of_nodes = 1'b0;
   endfunction

   // one request, with an optional hold-off before it
   task automatic send_item(input logic [KIND_W-1:0] kind, input logic [LETTER_W-1:0] letter,
                            input logic last, input logic empty);
      int gap;
      if (idle_on && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 10);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_type        <= kind;
      req_letter      <= letter;
      req_last_letter <= last;
      req_empty_word  <= empty;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_request(kind, letter, last, empty);
      requests_sent++;
   endtask

   // sends the current word; optionally ends it with an empty-word request
   task automatic send_word(input logic trail_empty);
      if (word_len == 0) begin
         send_item(word_kind[0], LETTER_W'($urandom_range(0, 31)),
                   1'($urandom_range(0, 1)), 1'b1);
      end else begin
         for (int i = 0; i < word_len; i++)
            send_item(word_kind[i], word_letter[i], (i == word_len - 1) && !trail_empty, 1'b0);
         if (trail_empty)
            send_item(word_kind[word_len - 1], LETTER_W'($urandom_range(0, 31)),
                      1'($urandom_range(0, 1)), 1'b1);
      end
   endtask

   task automatic make_word(input logic [KIND_W-1:0] kind, input int min_len,
                            input int max_len, input int top_letter);
      word_len = $urandom_range(min_len, max_len);
      for (int i = 0; i < MAX_LEN; i++) begin
         word_kind[i]   = kind;
         word_letter[i] = LETTER_W'($urandom_range(0, top_letter));
      end
   endtask

   task automatic remember_word();
      for (int i = 0; i < MAX_LEN; i++)
         dict_letter[dict_next][i] = word_letter[i];
      dict_len[dict_next] = word_len;
      dict_next           = (dict_next + 1) % DICT_SIZE;
      if (dict_count < DICT_SIZE)
         dict_count++;
   endtask

   task automatic recall_word(input int idx, input logic [KIND_W-1:0] kind);
      for (int i = 0; i < MAX_LEN; i++) begin
         word_letter[i] = dict_letter[idx][i];
         word_kind[i]   = kind;
      end
      word_len = dict_len[idx];
   endtask

   // empty words test and mark the root
   task automatic test_empty_word();
      send_item(REQ_PREFIX, LETTER_MAX, 1'b0, 1'b1);
      send_item(REQ_SEARCH, LETTER_A,   1'b1, 1'b1);
      send_item(REQ_INSERT, LETTER_Z,   1'b0, 1'b1);
      send_item(REQ_SEARCH, LETTER_A,   1'b0, 1'b1);
   endtask

   // insert at the letter extremes, then exact, partial and spare-kind lookups
   task automatic test_basic_words();
      send_item(REQ_INSERT, LETTER_Z, 1'b0, 1'b0);
      send_item(REQ_INSERT, LETTER_A, 1'b1, 1'b0);
      send_item(REQ_SEARCH, LETTER_Z, 1'b0, 1'b0);
      send_item(REQ_SEARCH, LETTER_A, 1'b1, 1'b0);
      send_item(REQ_SEARCH, LETTER_Z, 1'b1, 1'b0);
      send_item(REQ_SPARE,  LETTER_Z, 1'b1, 1'b0);
   endtask

   // letters past the alphabet break the walk; nodes linked before stay
   task automatic test_bad_letters();
      send_item(REQ_INSERT, LETTER_B,   1'b0, 1'b0);
      send_item(REQ_INSERT, LETTER_MAX, 1'b1, 1'b0);
      send_item(REQ_PREFIX, LETTER_BAD, 1'b1, 1'b0);
      send_item(REQ_PREFIX, LETTER_B,   1'b1, 1'b0);
   endtask

   // kind changes inside a word
   task automatic test_mixed_kinds();
      send_item(REQ_INSERT, LETTER_Z, 1'b0, 1'b0);
      send_item(REQ_SEARCH, LETTER_A, 1'b1, 1'b0);
      send_item(REQ_SEARCH, LETTER_B, 1'b0, 1'b0);
      send_item(REQ_INSERT, LETTER_A, 1'b1, 1'b0);
   endtask

   // letters after a missing child are ignored
   task automatic test_failed_walk();
      send_item(REQ_SEARCH, LETTER_D, 1'b0, 1'b0);
      send_item(REQ_SEARCH, LETTER_Z, 1'b0, 1'b0);
      send_item(REQ_SEARCH, LETTER_A, 1'b1, 1'b0);
   endtask

   // an empty-word request closes an open word
   task automatic test_empty_terminator();
      send_item(REQ_PREFIX, LETTER_Z, 1'b0, 1'b0);
      send_item(REQ_PREFIX, LETTER_A, 1'b0, 1'b1);
   endtask

   // mostly inserts and lookups of stored words over a narrow alphabet, plus noise
   task automatic test_random_words(input int budget, input logic allow_idle);
      int   stop_at;
      int   pick;
      int   cut;
      logic trail;
      stop_at = requests_sent + budget;
      while (requests_sent < stop_at) begin
         idle_on = allow_idle && ($urandom_range(0, 3) != 0);
         pick    = $urandom_range(0, 99);
         trail   = ($urandom_range(0, 9) == 0);
         if (pick < 40 || dict_count == 0) begin
            make_word(REQ_INSERT, 1, 5, ($urandom_range(0, 9) == 0) ? int'(LETTER_Z) : 2);
            remember_word();
         end else if (pick < 80) begin
            recall_word($urandom_range(0, dict_count - 1),
                        (pick < 62) ? REQ_SEARCH :
                        ($urandom_range(0, 3) != 0) ? REQ_PREFIX : REQ_SPARE);
            // cut short or stretch now and then
            cut = $urandom_range(0, 3);
            if (cut == 0 && word_len > 0) begin
               word_len--;
            end else if (cut == 1 && word_len < MAX_LEN) begin
               word_letter[word_len] = LETTER_W'($urandom_range(0, 2));
               word_len++;
            end
         end else if (pick < 86) begin
            word_len     = 0;
            word_kind[0] = KIND_W'($urandom_range(0, 3));
         end else if (pick < 93) begin
            make_word(KIND_W'($urandom_range(0, 3)), 1, 4, int'(LETTER_MAX));
         end else begin
            recall_word($urandom_range(0, dict_count - 1), REQ_SEARCH);
            for (int i = 0; i < MAX_LEN; i++)
               word_kind[i] = KIND_W'($urandom_range(0, 3));
         end
         send_word(trail);
      end
   endtask

   // long inserts until the node pool runs dry, then refusals next to old words
   task automatic test_pool_fill();
      idle_on = 1'b1;
      while (int'(free_ptr) < NODE_COUNT) begin
         make_word(REQ_INSERT, 10, MAX_LEN, int'(LETTER_Z));
         remember_word();
         send_word(1'b0);
         if ($urandom_range(0, 7) == 0) begin
            recall_word($urandom_range(0, dict_count - 1), REQ_SEARCH);
            send_word(1'b0);
         end
      end
      repeat (6) begin
         make_word(REQ_INSERT, 4, 8, int'(LETTER_Z));
         remember_word();
         send_word(1'b0);
         recall_word($urandom_range(0, dict_count - 1), KIND_W'($urandom_range(0, 3)));
         send_word(1'b0);
      end
   endtask

   // result side stalls in bursts of random length
   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= $urandom_range(0, 9);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // compare each result with the oldest expected verdict
   always @(posedge clock) begin : check_results
      verdict_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_verdicts.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual hit %0b no_room %0b",
                     $time, rsp_hit, rsp_no_room);
            fail_count++;
         end else begin
            want = pending_verdicts.pop_front();
            if (rsp_hit !== want.hit) begin
               $display("%0t: hit mismatch, expected %0b, actual %0b",
                        $time, want.hit, rsp_hit);
               fail_count++;
            end
            if (rsp_no_room !== want.no_room) begin
               $display("%0t: no_room mismatch, expected %0b, actual %0b",
                        $time, want.no_room, rsp_no_room);
               fail_count++;
            end
            results_seen++;
            if (want.hit)
               hits_seen++;
            if (want.no_room)
               refusals_seen++;
         end
      end
   end

   // watchdog on cycles with no request or result moving
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: timeout, nothing moved for %0d cycles", $time, QUIET_LIMIT);
         $display("Regression FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      for (int i = 0; i < LINK_DEPTH; i++)
         link_mem[i] = '0;
      for (int i = 0; i < NODE_COUNT; i++)
         term_mem[i] = 1'b0;
      free_ptr     = FREE_W'(1);
      cur_node     = '0;
      path_broken  = 1'b0;
      out_of_nodes = 1'b0;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_empty_word();
      test_basic_words();
      test_bad_letters();
      test_mixed_kinds();
      test_failed_walk();
      test_empty_terminator();
      test_random_words(150, 1'b1);
      test_pool_fill();
      test_random_words(80, 1'b0);

      // drain
      idle_on = 1'b0;
      req_valid <= 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d requests, checked %0d word results (%0d hits, %0d no-room refusals)",
               requests_sent, results_seen, hits_seen, refusals_seen);
      $display("Node pool use at end: %0d of %0d nodes", free_ptr, NODE_COUNT);
      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
design/pte_pkg.sv
design/pte_ram.sv
design/pte_walker.sv
design/prefix_trie_engine_unit.sv
sim/prefix_trie_engine_unit_tb.sv
